@@ rtl/gpke_pkg.sv @@
// Package with the key codes, button tables and control structs of the gamepad key event block.
package gpke_pkg;

	localparam int KEY_W       = 4;
	localparam int TOTAL_W     = 6;
	localparam int BTN_IDX_W   = 5;
	localparam int WORD_W      = 32;
	localparam int DIR_SLOTS   = 4;
	localparam int APB_ADDR_W  = 2;
	localparam int APB_DATA_W  = 32;

	localparam logic [APB_ADDR_W-1:0] CFG_ADDR_USE_KNOWN = 2'd0;

	localparam logic [KEY_W-1:0] KEY_NONE   = 4'd0;
	localparam logic [KEY_W-1:0] KEY_LEFT   = 4'd1;
	localparam logic [KEY_W-1:0] KEY_RIGHT  = 4'd2;
	localparam logic [KEY_W-1:0] KEY_UP     = 4'd3;
	localparam logic [KEY_W-1:0] KEY_DOWN   = 4'd4;
	localparam logic [KEY_W-1:0] KEY_SELECT = 4'd5;
	localparam logic [KEY_W-1:0] KEY_STICK  = 4'd6;
	localparam logic [KEY_W-1:0] KEY_START  = 4'd7;
	localparam logic [KEY_W-1:0] KEY_PGUP   = 4'd8;
	localparam logic [KEY_W-1:0] KEY_PGDN   = 4'd9;
	localparam logic [KEY_W-1:0] KEY_A      = 4'd10;
	localparam logic [KEY_W-1:0] KEY_B      = 4'd11;
	localparam logic [KEY_W-1:0] KEY_X      = 4'd12;
	localparam logic [KEY_W-1:0] KEY_Y      = 4'd13;
	localparam logic [KEY_W-1:0] KEY_HOME   = 4'd14;

	typedef struct packed {
		logic               operation;
		logic               report_ok;
		logic               dir_left;
		logic               dir_right;
		logic               dir_up;
		logic               dir_down;
		logic [WORD_W-1:0]  order_buttons;
		logic [WORD_W-1:0]  named_buttons;
		logic [TOTAL_W-1:0] button_total;
	} gpke_in_word_t;

	typedef struct packed {
		logic load;
		logic build_step;
		logic prep;
		logic scan_step;
		logic commit;
	} gpke_cmd_t;

	typedef struct packed {
		logic total_zero;
		logic build_last;
		logic pend_empty;
		logic here;
		logic last;
		logic out_free;
	} gpke_stat_t;

	function automatic logic [KEY_W-1:0] gpke_button_key(input logic known,
		input logic [BTN_IDX_W-1:0] idx);
		logic [KEY_W-1:0] key;
		key = KEY_NONE;
		if (known) begin
			unique case (idx)
				5'd0:    key = KEY_SELECT;
				5'd1:    key = KEY_STICK;
				5'd2:    key = KEY_STICK;
				5'd3:    key = KEY_START;
				5'd10:   key = KEY_PGUP;
				5'd11:   key = KEY_PGDN;
				5'd12:   key = KEY_Y;
				5'd13:   key = KEY_B;
				5'd14:   key = KEY_A;
				5'd15:   key = KEY_X;
				5'd16:   key = KEY_HOME;
				default: key = KEY_NONE;
			endcase
		end else begin
			unique case (idx)
				5'd0:    key = KEY_A;
				5'd1:    key = KEY_B;
				5'd2:    key = KEY_X;
				5'd3:    key = KEY_Y;
				5'd4:    key = KEY_START;
				5'd5:    key = KEY_SELECT;
				default: key = KEY_NONE;
			endcase
		end
		return key;
	endfunction

endpackage

@@ rtl/gpke_in_if.sv @@
// Input channel interface carrying one decoded gamepad report word.
interface gpke_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic        report_ok;
	logic        dir_left;
	logic        dir_right;
	logic        dir_up;
	logic        dir_down;
	logic [31:0] order_buttons;
	logic [31:0] named_buttons;
	logic [5:0]  button_total;

	modport source (output valid, operation, report_ok, dir_left, dir_right, dir_up, dir_down,
		order_buttons, named_buttons, button_total, input ready);
	modport sink (input valid, operation, report_ok, dir_left, dir_right, dir_up, dir_down,
		order_buttons, named_buttons, button_total, output ready);
endinterface

@@ rtl/gpke_out_if.sv @@
// Output channel interface carrying one key event word.
interface gpke_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] key_code;
	logic       key_down;
	logic       last_event;

	modport source (output valid, key_code, key_down, last_event, input ready);
	modport sink (input valid, key_code, key_down, last_event, output ready);
endinterface

@@ rtl/gpke_ctrl.sv @@
// Controller state machine that sequences the button build, slot scan and commit.
module gpke_ctrl
	import gpke_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_operation,
	input  logic       in_report_ok,
	output logic       in_ready,
	input  gpke_stat_t stat,
	output gpke_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_BUILD = 4'b0010,
		ST_PREP  = 4'b0100,
		ST_SCAN  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_operation) begin
						cmd.load = 1'b1;
						state_d  = ST_PREP;
					end else if (in_report_ok) begin
						cmd.load = 1'b1;
						state_d  = stat.total_zero ? ST_PREP : ST_BUILD;
					end
				end
			end
			ST_BUILD: begin
				cmd.build_step = 1'b1;
				if (stat.build_last) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.pend_empty) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.scan_step = !stat.here || stat.out_free;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/gpke_dp.sv @@
// Datapath with the slot arrays, held state, button scan and output word register.
module gpke_dp
	import gpke_pkg::*;
#(
	parameter int SLOT_COUNT  = 24,
	parameter int MAX_BUTTONS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          use_known,
	input  gpke_in_word_t in_word,
	input  gpke_cmd_t     cmd,
	output gpke_stat_t    stat,
	gpke_out_if.source    out_ch
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int NW = $clog2(SLOT_COUNT + 1);
	localparam int BW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
	localparam logic [NW-1:0]      SlotTotal = NW'(SLOT_COUNT);
	localparam logic [TOTAL_W-1:0] MaxTotal  = TOTAL_W'(MAX_BUTTONS);

	logic [KEY_W-1:0]      keys_q     [SLOT_COUNT];
	logic [KEY_W-1:0]      slot_key_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] press_q;
	logic [SLOT_COUNT-1:0] held_q;
	logic [SLOT_COUNT-1:0] pend_q;
	logic [SW-1:0]         sidx_q;
	logic [NW-1:0]         next_q;
	logic [BW-1:0]         bidx_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [MAX_BUTTONS-1:0] btn_q;
	logic                  out_valid_q;
	logic [KEY_W-1:0]      out_key_q;
	logic                  out_down_q;
	logic                  out_last_q;

	logic [KEY_W-1:0]      btn_key;
	logic                  btn_fits;
	logic [TOTAL_W-1:0]    bidx_next;
	logic [TOTAL_W-1:0]    total_eff;
	logic [WORD_W-1:0]     btn_sel;
	logic [SLOT_COUNT-1:0] cur_bit;
	logic [KEY_W-1:0]      emit_key;

	always_comb begin
		btn_key   = gpke_button_key(use_known, BTN_IDX_W'(bidx_q));
		btn_fits  = (btn_key != KEY_NONE) && (next_q < SlotTotal);
		bidx_next = TOTAL_W'(bidx_q) + TOTAL_W'(1);
		total_eff = (in_word.button_total > MaxTotal) ? MaxTotal : in_word.button_total;
		btn_sel   = use_known ? in_word.order_buttons : in_word.named_buttons;
		cur_bit   = SLOT_COUNT'(1) << sidx_q;
		emit_key  = (keys_q[sidx_q] != KEY_NONE) ? keys_q[sidx_q] : slot_key_q[sidx_q];

		stat.total_zero = (in_word.button_total == '0);
		stat.build_last = (bidx_next == total_q);
		stat.pend_empty = (pend_q == '0);
		stat.here       = pend_q[sidx_q];
		stat.last       = ((pend_q & ~cur_bit) == '0);
		stat.out_free   = !out_valid_q || out_ch.ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = DIR_SLOTS; i < SLOT_COUNT; i++) begin
				keys_q[i] <= KEY_NONE;
			end
			keys_q[0] <= in_word.operation ? KEY_NONE : KEY_LEFT;
			keys_q[1] <= in_word.operation ? KEY_NONE : KEY_RIGHT;
			keys_q[2] <= in_word.operation ? KEY_NONE : KEY_UP;
			keys_q[3] <= in_word.operation ? KEY_NONE : KEY_DOWN;
			press_q   <= in_word.operation ? '0 :
				{{(SLOT_COUNT-DIR_SLOTS){1'b0}}, in_word.dir_down, in_word.dir_up,
				in_word.dir_right, in_word.dir_left};
			next_q  <= NW'(DIR_SLOTS);
			bidx_q  <= '0;
			total_q <= total_eff;
			btn_q   <= btn_sel[MAX_BUTTONS-1:0];
		end else if (cmd.build_step) begin
			if (btn_fits) begin
				keys_q[next_q[SW-1:0]]  <= btn_key;
				press_q[next_q[SW-1:0]] <= btn_q[bidx_q];
				next_q                  <= next_q + NW'(1);
			end
			bidx_q <= bidx_q + BW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pend_q <= '0;
			sidx_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_key_q[i] <= KEY_NONE;
			end
		end else begin
			if (cmd.prep) begin
				pend_q <= held_q ^ press_q;
				sidx_q <= '0;
			end else if (cmd.scan_step) begin
				pend_q[sidx_q] <= 1'b0;
				sidx_q         <= sidx_q + SW'(1);
			end
			if (cmd.commit) begin
				held_q <= press_q;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					slot_key_q[i] <= keys_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.scan_step && stat.here) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && stat.here) begin
			out_key_q  <= emit_key;
			out_down_q <= press_q[sidx_q];
			out_last_q <= stat.last;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.key_code   = out_key_q;
	assign out_ch.key_down   = out_down_q;
	assign out_ch.last_event = out_last_q;

endmodule

@@ rtl/gamepad_report_to_key_events_top.sv @@
// Top level of the gamepad report to key event block with its register port.
// No new word is taken until the block has built the button slots, scanned up to the last changed slot
// and committed the held state. The build handles one button per cycle and the scan one slot per
// cycle; a stalled output word holds the scan on that slot.
// Reset clears the held mask, every stored slot key, the map select register and the controller.
module gamepad_report_to_key_events_top
	import gpke_pkg::*;
#(
	parameter int SLOT_COUNT  = 24,
	parameter int MAX_BUTTONS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	gpke_in_if.sink               in_ch,
	gpke_out_if.source            out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic          use_known_q;
	logic          cfg_write;
	gpke_in_word_t in_word;
	gpke_cmd_t     cmd;
	gpke_stat_t    stat;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr == CFG_ADDR_USE_KNOWN);
	assign prdata    = (paddr == CFG_ADDR_USE_KNOWN) ? {{(APB_DATA_W-1){1'b0}}, use_known_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_known_q <= 1'b0;
		end else if (cfg_write) begin
			use_known_q <= pwdata[0];
		end
	end

	always_comb begin
		in_word.operation     = in_ch.operation;
		in_word.report_ok     = in_ch.report_ok;
		in_word.dir_left      = in_ch.dir_left;
		in_word.dir_right     = in_ch.dir_right;
		in_word.dir_up        = in_ch.dir_up;
		in_word.dir_down      = in_ch.dir_down;
		in_word.order_buttons = in_ch.order_buttons;
		in_word.named_buttons = in_ch.named_buttons;
		in_word.button_total  = in_ch.button_total;
	end

	gpke_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_operation (in_ch.operation),
		.in_report_ok (in_ch.report_ok),
		.in_ready     (in_ch.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	gpke_dp #(
		.SLOT_COUNT  (SLOT_COUNT),
		.MAX_BUTTONS (MAX_BUTTONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.use_known (use_known_q),
		.in_word   (in_word),
		.cmd       (cmd),
		.stat      (stat),
		.out_ch    (out_ch)
	);

	// No scan work may be left over while new words are taken.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> stat.pend_empty)
		else $error("pending slot events while accepting input");

	// A word is only written into the output register when that register can take it.
	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && stat.here) |-> (!out_ch.valid || out_ch.ready))
		else $error("event emitted over an untaken output word");

	// The word marked last leaves no further events pending.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && stat.here && stat.last) |=> stat.pend_empty)
		else $error("events still pending after the last event");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the gamepad report to key event block, with its own event predictor.
module tb_top;
	import gpke_pkg::*;

	localparam int SLOTS         = 24;
	localparam int BUTTON_LIMIT  = 32;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_WORDS   = 70;

	typedef struct packed {
		logic [KEY_W-1:0] key_code;
		logic             key_down;
		logic             last_event;
	} key_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	gpke_in_if  in_ch ();
	gpke_out_if out_ch ();

	logic [SLOTS-1:0] shadow_held;
	logic [KEY_W-1:0] shadow_keys [SLOTS];
	logic             shadow_known;
	key_event_t       pending_events [$];
	gpke_in_word_t    last_report;
	int unsigned      cycle_count;
	int unsigned      error_count;
	int unsigned      words_sent;
	int unsigned      events_seen;
	bit               quiet_mode;

	gamepad_report_to_key_events_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d key events outstanding.",
				pending_events.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [KEY_W-1:0] known_button_key(input int idx);
		case (idx)
			0:       return KEY_SELECT;
			1, 2:    return KEY_STICK;
			3:       return KEY_START;
			10:      return KEY_PGUP;
			11:      return KEY_PGDN;
			12:      return KEY_Y;
			13:      return KEY_B;
			14:      return KEY_A;
			15:      return KEY_X;
			16:      return KEY_HOME;
			default: return KEY_NONE;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] generic_button_key(input int idx);
		case (idx)
			0:       return KEY_A;
			1:       return KEY_B;
			2:       return KEY_X;
			3:       return KEY_Y;
			4:       return KEY_START;
			5:       return KEY_SELECT;
			default: return KEY_NONE;
		endcase
	endfunction

	// Works out the key events of one accepted word and updates the shadow slot state.
	task automatic predict_key_events(input gpke_in_word_t w);
		logic [KEY_W-1:0] keys [SLOTS];
		logic [SLOTS-1:0] pressed;
		logic [SLOTS-1:0] filled;
		logic [KEY_W-1:0] key;
		key_event_t       batch [$];
		key_event_t       ev;
		int               total;
		int               free_slot;
		if (w.operation) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (shadow_held[i]) begin
					ev = '{shadow_keys[i], 1'b0, 1'b0};
					batch.push_back(ev);
				end
				shadow_keys[i] = KEY_NONE;
			end
			shadow_held = '0;
		end else if (w.report_ok) begin
			pressed = '0;
			filled = '0;
			for (int i = 0; i < SLOTS; i++)
				keys[i] = KEY_NONE;
			keys[0] = KEY_LEFT;
			keys[1] = KEY_RIGHT;
			keys[2] = KEY_UP;
			keys[3] = KEY_DOWN;
			pressed[3:0] = {w.dir_down, w.dir_up, w.dir_right, w.dir_left};
			filled[3:0] = '1;
			total = (w.button_total > 6'(BUTTON_LIMIT)) ? BUTTON_LIMIT : int'(w.button_total);
			free_slot = DIR_SLOTS;
			for (int b = 0; b < total; b++) begin
				key = shadow_known ? known_button_key(b) : generic_button_key(b);
				if (key != KEY_NONE && free_slot < SLOTS) begin
					keys[free_slot] = key;
					pressed[free_slot] = shadow_known ? w.order_buttons[b] : w.named_buttons[b];
					filled[free_slot] = 1'b1;
					free_slot++;
				end
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (shadow_held[i] != pressed[i]) begin
					ev = '{filled[i] ? keys[i] : shadow_keys[i], pressed[i], 1'b0};
					batch.push_back(ev);
				end
				shadow_keys[i] = keys[i];
			end
			shadow_held = pressed;
		end
		if (batch.size() > 0)
			batch[batch.size()-1].last_event = 1'b1;
		foreach (batch[i])
			pending_events.push_back(batch[i]);
	endtask

	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			events_seen++;
			if (pending_events.size() == 0) begin
				$error("Unexpected key event: key_code %0d key_down %0d last_event %0d",
					out_ch.key_code, out_ch.key_down, out_ch.last_event);
				error_count++;
			end else begin
				want = pending_events.pop_front();
				if (out_ch.key_code !== want.key_code) begin
					$error("key_code mismatch: expected %0d, actual %0d", want.key_code,
						out_ch.key_code);
					error_count++;
				end
				if (out_ch.key_down !== want.key_down) begin
					$error("key_down mismatch: expected %0d, actual %0d", want.key_down,
						out_ch.key_down);
					error_count++;
				end
				if (out_ch.last_event !== want.last_event) begin
					$error("last_event mismatch: expected %0d, actual %0d", want.last_event,
						out_ch.last_event);
					error_count++;
				end
			end
		end
	end

	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet_mode ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(out_ch.valid && out_ch.ready))
				@(posedge clk);
		end
	end

	task automatic send_word(input gpke_in_word_t w);
		int gap;
		gap = quiet_mode ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.operation     <= w.operation;
		in_ch.report_ok     <= w.report_ok;
		in_ch.dir_left      <= w.dir_left;
		in_ch.dir_right     <= w.dir_right;
		in_ch.dir_up        <= w.dir_up;
		in_ch.dir_down      <= w.dir_down;
		in_ch.order_buttons <= w.order_buttons;
		in_ch.named_buttons <= w.named_buttons;
		in_ch.button_total  <= w.button_total;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_key_events(w);
		words_sent++;
	endtask

	function automatic gpke_in_word_t report_word(input logic ok, input logic [3:0] dirs,
		input logic [31:0] order, input logic [31:0] named, input logic [5:0] total);
		gpke_in_word_t w;
		w.operation = 1'b0;
		w.report_ok = ok;
		{w.dir_left, w.dir_right, w.dir_up, w.dir_down} = dirs;
		w.order_buttons = order;
		w.named_buttons = named;
		w.button_total = total;
		return w;
	endfunction

	function automatic gpke_in_word_t disconnect_word(input logic ok);
		gpke_in_word_t w;
		w = report_word(ok, 4'($urandom), $urandom, $urandom, 6'($urandom));
		w.operation = 1'b1;
		return w;
	endfunction

	task automatic wait_for_idle();
		in_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the map select register with the block idle, then reads it back.
	task automatic write_map_select(input logic known);
		wait_for_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_USE_KNOWN;
		pwdata  <= APB_DATA_W'(known);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		shadow_known = known;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(known)) begin
			$error("use_known_map readback mismatch: expected %0h, actual %0h",
				APB_DATA_W'(known), prdata);
			error_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// The generic map is the reset setting, so this part runs without a register write.
	task automatic test_generic_map_directed();
		send_word(report_word(1'b0, 4'hf, '1, '1, 6'd32));
		send_word(report_word(1'b1, 4'hf, '1, '1, 6'd32));
		send_word(report_word(1'b1, 4'hf, '1, '1, 6'd32));
		send_word(report_word(1'b1, 4'h0, '0, '0, 6'd0));
		send_word(report_word(1'b1, 4'ha, '0, '1, 6'd63));
		send_word(report_word(1'b1, 4'ha, '0, '1, 6'd2));
		send_word(report_word(1'b1, 4'h5, '0, 32'h0000_0015, 6'd6));
		send_word(disconnect_word(1'b0));
		send_word(disconnect_word(1'b1));
		send_word(report_word(1'b1, 4'h0, '0, 32'h0000_0001, 6'd1));
	endtask

	// The first report after the switch keeps slot 4 pressed under a new key.
	task automatic test_known_map_directed();
		write_map_select(1'b1);
		send_word(report_word(1'b1, 4'h0, 32'h0000_0001, '0, 6'd1));
		send_word(report_word(1'b1, 4'h0, '0, '0, 6'd0));
		send_word(report_word(1'b1, 4'hf, '1, '0, 6'd32));
		send_word(report_word(1'b1, 4'hf, '1, '0, 6'd16));
		send_word(report_word(1'b1, 4'hf, '1, '0, 6'd17));
		send_word(report_word(1'b1, 4'hf, 32'h0000_03f0, '0, 6'd32));
		send_word(report_word(1'b1, 4'h0, 32'hffff_0000, '1, 6'd40));
		send_word(report_word(1'b1, 4'h0, '1, '1, 6'd0));
		send_word(report_word(1'b0, 4'h0, '1, '1, 6'd32));
		send_word(report_word(1'b1, 4'h1, '0, '0, 6'd0));
		send_word(disconnect_word(1'b1));
		send_word(disconnect_word(1'b0));
	endtask

	function automatic gpke_in_word_t random_word(input gpke_in_word_t prev);
		gpke_in_word_t w;
		int pick;
		int bit_idx;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			w = disconnect_word(1'($urandom_range(0, 1)));
		end else if (pick < 16) begin
			w = report_word(1'b0, 4'($urandom), $urandom, $urandom, 6'($urandom));
		end else if (pick < 46) begin
			w = prev;
			w.operation = 1'b0;
			w.report_ok = 1'b1;
			bit_idx = $urandom_range(0, 68);
			if (bit_idx < 4)
				w.dir_left ^= (bit_idx == 0);
			if (bit_idx == 1)
				w.dir_right ^= 1'b1;
			if (bit_idx == 2)
				w.dir_up ^= 1'b1;
			if (bit_idx == 3)
				w.dir_down ^= 1'b1;
			if (bit_idx >= 4 && bit_idx < 36)
				w.order_buttons[bit_idx-4] ^= 1'b1;
			if (bit_idx >= 36 && bit_idx < 68)
				w.named_buttons[bit_idx-36] ^= 1'b1;
			if (bit_idx == 68)
				w.button_total = 6'($urandom_range(0, 32));
		end else begin
			w = report_word(1'b1, 4'($urandom), $urandom, $urandom, 6'd0);
			if ($urandom_range(0, 2) == 0) begin
				w.order_buttons &= $urandom;
				w.named_buttons &= $urandom;
			end
			if ($urandom_range(0, 99) < 85)
				w.button_total = 6'($urandom_range(0, 32));
			else
				w.button_total = 6'($urandom_range(33, 63));
		end
		return w;
	endfunction

	// Phases alternate the map select; one phase runs with both sides never idling.
	task automatic test_random_traffic();
		gpke_in_word_t w;
		int counted;
		for (int phase = 0; phase < 6; phase++) begin
			write_map_select(phase[0]);
			quiet_mode = (phase == 3);
			counted = 0;
			while (counted < PHASE_WORDS) begin
				w = random_word(last_report);
				send_word(w);
				if (w.operation || w.report_ok) begin
					counted++;
					if (!w.operation)
						last_report = w;
				end
			end
		end
		quiet_mode = 1'b0;
	endtask

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		in_ch.valid         = 1'b0;
		in_ch.operation     = 1'b0;
		in_ch.report_ok     = 1'b0;
		in_ch.dir_left      = 1'b0;
		in_ch.dir_right     = 1'b0;
		in_ch.dir_up        = 1'b0;
		in_ch.dir_down      = 1'b0;
		in_ch.order_buttons = '0;
		in_ch.named_buttons = '0;
		in_ch.button_total  = '0;
		shadow_held         = '0;
		shadow_known        = 1'b0;
		quiet_mode          = 1'b0;
		last_report         = report_word(1'b1, 4'h0, '0, '0, 6'd0);
		for (int i = 0; i < SLOTS; i++)
			shadow_keys[i] = KEY_NONE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_generic_map_directed();
		test_known_map_directed();
		test_random_traffic();
		wait_for_idle();
		$display("Sent %0d words (reports, invalid reports, disconnects) under both button maps.",
			words_sent);
		$display("Checked %0d key events with %0d mismatches.", events_seen, error_count);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
